// File: sv/kmp_stream_matcher_macros.svh
// Assertion macros shared by the matcher RTL.
`ifndef KMP_STREAM_MATCHER_MACROS_SVH
`define KMP_STREAM_MATCHER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KMP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmp_stream_matcher: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define KMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmp_stream_matcher: next-cycle check failed");

`endif

// File: sv/kmp_pkg.sv
// Shared constants and types of the streaming KMP matcher.
`timescale 1ns / 1ps

package kmp_pkg;

  localparam int MAX_PATTERN   = 32;
  localparam int POSITION_BITS = 32;
  localparam int IDX_W         = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
  localparam int SYM_W         = 8;
  localparam int START_W       = 32;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [SYM_W-1:0]         sym_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [START_W-1:0]       start_t;

  // Mode codes of an input item.
  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_TEXT    = 1'b1;

  typedef struct packed {
    logic mode;
    sym_t symbol;
    logic first;
    logic last;
  } item_t;

  typedef struct packed {
    logic   valid;
    logic   match;
    start_t match_start;
    logic   end_of_text;
    logic   none_found;
  } result_t;

endpackage

// File: sv/kmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/kmp_engine.sv
// Sequencer and shared compare/fallback unit of the KMP matcher.
`timescale 1ns / 1ps

module kmp_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  kmp_pkg::item_t   item,
  input  logic             slot_free,
  output logic             idle,
  output kmp_pkg::result_t res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOADK = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]    state, state_next;
  logic          mode_r, mode_r_next;
  kmp_pkg::sym_t sym, sym_next;
  logic          last_r, last_r_next;
  logic          hit, hit_next;
  logic          seen, seen_next;
  kmp_pkg::len_t len, len_next;
  kmp_pkg::len_t matched, matched_next;
  kmp_pkg::len_t j, j_next;
  kmp_pkg::pos_t pos, pos_next;

  logic          p_we, t_we;
  kmp_pkg::idx_t p_waddr, t_waddr, p_raddr, t_raddr;
  kmp_pkg::sym_t p_rdata;
  kmp_pkg::len_t t_wdata, t_rdata;

  kmp_pkg::len_t len_eff, j_start, jj;
  kmp_pkg::pos_t start_full;

  kmp_ram #(.WIDTH(kmp_pkg::SYM_W), .DEPTH(kmp_pkg::MAX_PATTERN)) u_pattern (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (item.symbol),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  kmp_ram #(.WIDTH(kmp_pkg::LEN_W), .DEPTH(kmp_pkg::MAX_PATTERN)) u_prefix (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign idle       = (state == S_IDLE);
  assign start_full = pos + kmp_pkg::pos_t'(1) - kmp_pkg::pos_t'(len);

  always_comb begin
    state_next   = state;
    mode_r_next  = mode_r;
    sym_next     = sym;
    last_r_next  = last_r;
    hit_next     = hit;
    seen_next    = seen;
    len_next     = len;
    matched_next = matched;
    j_next       = j;
    pos_next     = pos;
    p_we         = 1'b0;
    p_waddr      = kmp_pkg::idx_t'(len);
    t_we         = 1'b0;
    t_waddr      = kmp_pkg::idx_t'(len);
    t_wdata      = '0;
    p_raddr      = kmp_pkg::idx_t'(j);
    t_raddr      = kmp_pkg::idx_t'(j - kmp_pkg::len_t'(1));
    res          = '0;

    len_eff = (item.first && item.mode == kmp_pkg::MODE_PATTERN) ? '0 : len;
    j_start = (item.first) ? '0 : matched;
    if (j_start >= len) begin
      j_start = '0;
    end
    jj = (p_rdata == sym) ? j + kmp_pkg::len_t'(1) : j;

    case (state)
      S_IDLE: begin
        if (accept) begin
          mode_r_next = item.mode;
          sym_next    = item.symbol;
          last_r_next = item.last;
          if (item.mode == kmp_pkg::MODE_PATTERN) begin
            len_next = len_eff;
            if (item.first) begin
              matched_next = '0;
            end
            if (len_eff < kmp_pkg::len_t'(kmp_pkg::MAX_PATTERN)) begin
              p_we    = 1'b1;
              p_waddr = kmp_pkg::idx_t'(len_eff);
              if (len_eff == '0) begin
                // first byte: its prefix entry is zero
                t_we     = 1'b1;
                t_waddr  = '0;
                t_wdata  = '0;
                len_next = kmp_pkg::len_t'(1);
              end else begin
                t_raddr    = kmp_pkg::idx_t'(len_eff - kmp_pkg::len_t'(1));
                state_next = S_LOADK;
              end
            end
          end else begin
            if (item.first) begin
              pos_next  = '0;
              seen_next = 1'b0;
            end
            matched_next = j_start;
            hit_next     = 1'b0;
            if (len == '0) begin
              state_next = S_EMIT;
            end else begin
              j_next     = j_start;
              p_raddr    = kmp_pkg::idx_t'(j_start);
              t_raddr    = kmp_pkg::idx_t'(j_start - kmp_pkg::len_t'(1));
              state_next = S_WALK;
            end
          end
        end
      end

      S_LOADK: begin
        // start the walk from the previous entry's border
        j_next     = t_rdata;
        p_raddr    = kmp_pkg::idx_t'(t_rdata);
        t_raddr    = kmp_pkg::idx_t'(t_rdata - kmp_pkg::len_t'(1));
        state_next = S_WALK;
      end

      S_WALK: begin
        if (j != '0 && p_rdata != sym) begin
          j_next  = t_rdata;
          p_raddr = kmp_pkg::idx_t'(t_rdata);
          t_raddr = kmp_pkg::idx_t'(t_rdata - kmp_pkg::len_t'(1));
        end else if (mode_r == kmp_pkg::MODE_PATTERN) begin
          t_we       = 1'b1;
          t_waddr    = kmp_pkg::idx_t'(len);
          t_wdata    = jj;
          len_next   = len + kmp_pkg::len_t'(1);
          state_next = S_IDLE;
        end else if (jj == len) begin
          hit_next   = 1'b1;
          t_raddr    = kmp_pkg::idx_t'(jj - kmp_pkg::len_t'(1));
          state_next = S_TAIL;
        end else begin
          matched_next = jj;
          state_next   = S_EMIT;
        end
      end

      S_TAIL: begin
        // resume from the border of the full match
        matched_next = t_rdata;
        state_next   = S_EMIT;
      end

      S_EMIT: begin
        if (slot_free) begin
          res.valid       = 1'b1;
          res.match       = hit;
          res.match_start = hit ? kmp_pkg::start_t'(start_full) : '0;
          res.end_of_text = last_r;
          res.none_found  = last_r && !(seen || hit);
          seen_next       = seen || hit;
          pos_next        = pos + kmp_pkg::pos_t'(1);
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      len     <= '0;
      matched <= '0;
      pos     <= '0;
      seen    <= 1'b0;
    end else begin
      state   <= state_next;
      len     <= len_next;
      matched <= matched_next;
      pos     <= pos_next;
      seen    <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_r_next;
    sym    <= sym_next;
    last_r <= last_r_next;
    hit    <= hit_next;
    j      <= j_next;
  end

endmodule

// File: sv/kmp_stream_matcher.sv
// Top level of the streaming KMP exact byte matcher.
// Usage:
//   Input channel s_*: one item per byte. s_tuser[0] selects pattern (0) or text (1),
//   s_tuser[1] starts a new pattern or a new text, s_tlast marks the final text byte.
//   Pattern items are appended to the pattern store and extend the border table;
//   bytes beyond the pattern capacity are dropped. Pattern items give no result.
//   Output channel m_*: one item per text byte, with the match flag, the start offset
//   of a match ending at that byte, end of text and "no match in this text".
// Sequencing:
//   A text item is accepted while idle and walks the border table one fallback at a
//   time; a completed match then looks up the border of the full match to resume, and
//   the result goes to the output register. The next item is accepted only after the
//   result is handed over, so no new byte is taken before the last one is through. A
//   pattern item that is the first byte or is dropped ends at acceptance; any other
//   reads the previous entry's border, then walks and writes its table entry. The pace
//   is set by the single compare/fallback unit and the registered read port of the two
//   stores; fallbacks average at most one per byte. s_tready is high only while idle.
// Reset clears lengths, text position and the seen-match flag; the stores are not cleared.
// A stalled receiver holds the result in the output register; the next item is still
// accepted and worked on, and its result waits until the register frees.
`timescale 1ns / 1ps
`include "kmp_stream_matcher_macros.svh"

module kmp_stream_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic [1:0]  s_tuser,   // [0] mode, [1] first
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] match_start
  output logic [1:0]  m_tuser,   // [0] match, [1] none_found
  output logic        m_tlast    // end_of_text
);

  kmp_pkg::item_t   item;
  kmp_pkg::result_t res;
  logic             accept;
  logic             idle;
  logic             slot_free;

  // Unpack the input item: mode, symbol, first, last
  assign item = {s_tuser[0], s_tdata, s_tuser[1], s_tlast};

  assign s_tready  = idle;
  assign accept    = s_tvalid && s_tready;
  // the output register frees when empty or being taken this cycle
  assign slot_free = !m_tvalid || m_tready;

  kmp_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .slot_free (slot_free),
    .idle      (idle),
    .res       (res)
  );

  // Output register: load a fresh result, drop the held one once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata    <= res.match_start;
      m_tuser[0] <= res.match;
      m_tuser[1] <= res.none_found;
      m_tlast    <= res.end_of_text;
    end
  end

  // A result never overwrites one still waiting
  `KMP_ASSERT_NOW(a_no_overwrite, res.valid, !m_tvalid || m_tready)
  // Without a match the start offset reads zero
  `KMP_ASSERT_NOW(a_start_zero, m_tvalid && !m_tuser[0], m_tdata == 32'd0)
  // "No match" is only reported at the end of a text, and never alongside a match
  `KMP_ASSERT_NOW(a_none_at_end, m_tvalid && m_tuser[1], m_tlast && !m_tuser[0])
  // An emitted result lands in the output register
  `KMP_ASSERT_NEXT(a_result_lands, res.valid, m_tvalid)

endmodule
